// ===== src/snsc_pkg.sv =====
package snsc_pkg;

    // Fixed field widths of the stream and register interfaces.
    localparam int IDX_W   = 12;
    localparam int PVAL_W  = 17;
    localparam int COUNT_W = 15;
    localparam int SLEN_W  = 15;
    localparam int PCNT_W  = 13;

    // Command codes carried in the input tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_COUNT = 1'b1;

    // Status that the divider reports back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/snsc_div.sv =====
module snsc_div
    import snsc_pkg::*;
#(
    parameter int VALUE_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [PVAL_W-1:0]     divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [PVAL_W-1:0]     remainder,
    output div_status_t           status
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [PVAL_W-1:0]     rem_reg, rem_next;
    logic [PVAL_W-1:0]     dsr_reg, dsr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PVAL_W:0]       trial;

    // One restoring step per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = PVAL_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PVAL_W-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== src/smooth_number_segment_counter_core.sv =====
// A count beat works through fill, then per table entry of 2 or more a division for the start
// residue, one for each nonzero multiple in the segment and one for each further division on
// it, then tally and result load, on a shared bit-serial divider and a single cofactor memory
// port. One beat is worked at a time; an empty or out-of-range segment goes straight to the
// result load, and an in-range load beat is written to the prime table. Reset clears control
// state and the prime count, sets segment length to 16384; both memories are undefined until written.
module smooth_number_segment_counter_core
    import snsc_pkg::*;
#(
    parameter int MAX_PRIMES = 4096,
    parameter int SEG_MAX    = 16384,
    parameter int VALUE_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata fields, low bit up: prime_index, prime_value, seg_start, zero fill.
    input  logic [((IDX_W+PVAL_W+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser fields: cmd.
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata fields, low bit up: smooth_count, range_error.
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW  = $clog2(SEG_MAX + 1);
    localparam int SAW = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
    localparam int KW  = $clog2(MAX_PRIMES + 1);
    localparam int TAW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int IW  = ((LW > PVAL_W) ? LW : PVAL_W) + 1;
    localparam int VB  = VALUE_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_PRD   = 4'd2;
    localparam logic [3:0] S_PWAIT = 4'd3;
    localparam logic [3:0] S_RDIV  = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CWAIT = 4'd6;
    localparam logic [3:0] S_CDIV  = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_TACC  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // Configuration registers.
    logic [SLEN_W-1:0] seg_len_reg;
    logic [PCNT_W-1:0] prime_count_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_len_reg     <= SLEN_W'(16384);
            prime_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                prime_count_reg <= pwdata[PCNT_W-1:0];
            else
                seg_len_reg <= pwdata[SLEN_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'(prime_count_reg) : 32'(seg_len_reg);

    // Input fields.
    logic [IDX_W-1:0]  in_idx;
    logic [PVAL_W-1:0] in_pval;
    logic [VB-1:0]     in_start;
    logic              in_acc;

    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_pval  = s_tdata[IDX_W +: PVAL_W];
    assign in_start = s_tdata[IDX_W+PVAL_W +: VB];
    assign in_acc   = s_tvalid && s_tready;

    // Saturated length and prime count.
    logic [31:0] len_sat, pc_sat;
    logic [LW:0] len_m1;
    logic [VB:0] end_sum;

    always_comb
    begin
        len_sat = (32'(seg_len_reg) > 32'(SEG_MAX)) ? 32'(SEG_MAX) : 32'(seg_len_reg);
        pc_sat  = (32'(prime_count_reg) > 32'(MAX_PRIMES)) ? 32'(MAX_PRIMES)
                                                           : 32'(prime_count_reg);
        len_m1  = (LW+1)'(len_sat) - (LW+1)'(1);
        end_sum = {1'b0, in_start} + (VB+1)'(len_m1);
    end

    // Sequencer state.
    logic [3:0]         state_reg, state_next;
    logic [VB-1:0]      start_reg, start_next;
    logic [VB-1:0]      n_reg, n_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [KW-1:0]      pc_reg, pc_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [PVAL_W-1:0]  p_reg, p_next;
    logic [VB-1:0]      c_reg, c_next;
    logic [LW-1:0]      cnt_reg, cnt_next;
    logic               err_reg, err_next;
    logic [15:0]        out_reg, out_next;
    logic               out_vld_reg, out_vld_next;

    // Memories.
    logic [PVAL_W-1:0]  ptab_mem [MAX_PRIMES];
    logic [PVAL_W-1:0]  ptab_rdata_reg;
    logic [VB-1:0]      cof_mem [SEG_MAX];
    logic [VB-1:0]      cof_rdata_reg;
    logic               cof_we;
    logic [VB-1:0]      cof_wdata;
    logic [SAW-1:0]     cof_addr;
    logic               ptab_we;

    // Divider.
    logic               div_start;
    logic [VB-1:0]      div_dividend;
    logic [VB-1:0]      div_quo;
    logic [PVAL_W-1:0]  div_rem;
    div_status_t        div_st;

    snsc_div #(
        .VALUE_BITS (VB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (p_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_st)
    );

    logic [IW-1:0] i_step;
    logic [IW-1:0] i_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign ptab_we  = in_acc && (s_tuser == CMD_LOAD) && (32'(in_idx) < 32'(MAX_PRIMES));
    assign cof_addr = i_reg[SAW-1:0];
    assign i_step   = IW'(i_reg + IW'(p_reg));
    assign i_inc    = i_reg + IW'(1);

    // Main sequencer: fill, sieve prime by prime, then tally.
    always_comb
    begin
        state_next   = state_reg;
        start_next   = start_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        pc_next      = pc_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        p_next       = p_reg;
        c_next       = c_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        cof_we       = 1'b0;
        cof_wdata    = n_reg;
        div_start    = 1'b0;
        div_dividend = start_reg;

        if (m_tvalid && m_tready)
            out_vld_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_tuser != CMD_LOAD))
                begin
                    start_next = in_start;
                    n_next     = in_start;
                    len_next   = LW'(len_sat);
                    pc_next    = KW'(pc_sat);
                    k_next     = '0;
                    i_next     = '0;
                    cnt_next   = '0;
                    err_next   = 1'b0;
                    if (len_sat == 32'd0)
                        state_next = S_DONE;
                    else if (end_sum[VB])
                    begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cof_we    = 1'b1;
                cof_wdata = n_reg;
                n_next    = n_reg + VB'(1);
                i_next    = i_inc;
                if (i_inc >= IW'(len_reg))
                begin
                    i_next = '0;
                    n_next = start_reg;
                    state_next = (pc_reg == '0) ? S_TRD : S_PRD;
                end
            end
            S_PRD:
                state_next = S_PWAIT;
            S_PWAIT:
            begin
                p_next = ptab_rdata_reg;
                if (ptab_rdata_reg < PVAL_W'(2))
                begin
                    k_next = k_reg + KW'(1);
                    state_next = ((k_reg + KW'(1)) >= pc_reg) ? S_TRD : S_PRD;
                end
                else
                    state_next = S_RDIV;
            end
            S_RDIV:
            begin
                // The divider starts here with the new divisor in p_reg.
                if (!div_st.busy && !div_st.done)
                begin
                    div_start    = 1'b1;
                    div_dividend = start_reg;
                end
                else if (div_st.done)
                begin
                    i_next = (div_rem == '0) ? '0 : IW'(p_reg - div_rem);
                    if (((div_rem == '0) ? IW'(0) : IW'(p_reg - div_rem)) >= IW'(len_reg))
                    begin
                        k_next = k_reg + KW'(1);
                        i_next = '0;
                        state_next = ((k_reg + KW'(1)) >= pc_reg) ? S_TRD : S_PRD;
                    end
                    else
                        state_next = S_CRD;
                end
            end
            S_CRD:
                state_next = S_CWAIT;
            S_CWAIT:
            begin
                c_next = cof_rdata_reg;
                if (cof_rdata_reg == '0)
                begin
                    // Zero is left alone; step to the next multiple.
                    i_next = i_step;
                    if (i_step >= IW'(len_reg))
                    begin
                        k_next = k_reg + KW'(1);
                        i_next = '0;
                        state_next = ((k_reg + KW'(1)) >= pc_reg) ? S_TRD : S_PRD;
                    end
                    else
                        state_next = S_CRD;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = cof_rdata_reg;
                    state_next   = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (div_st.done)
                begin
                    if (div_rem == '0)
                    begin
                        c_next       = div_quo;
                        div_start    = 1'b1;
                        div_dividend = div_quo;
                    end
                    else
                    begin
                        cof_we    = 1'b1;
                        cof_wdata = c_reg;
                        i_next    = i_step;
                        if (i_step >= IW'(len_reg))
                        begin
                            k_next = k_reg + KW'(1);
                            i_next = '0;
                            state_next = ((k_reg + KW'(1)) >= pc_reg) ? S_TRD : S_PRD;
                        end
                        else
                            state_next = S_CRD;
                    end
                end
            end
            S_TRD:
                state_next = S_TACC;
            S_TACC:
            begin
                if ((n_reg <= VB'(1)) || (cof_rdata_reg == VB'(1)))
                    cnt_next = cnt_reg + LW'(1);
                n_next = n_reg + VB'(1);
                i_next = i_inc;
                state_next = (i_inc >= IW'(len_reg)) ? S_DONE : S_TRD;
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_next     = {err_reg, COUNT_W'(32'(cnt_reg))};
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        n_reg     <= n_next;
        len_reg   <= len_next;
        pc_reg    <= pc_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        p_reg     <= p_next;
        c_reg     <= c_next;
        cnt_reg   <= cnt_next;
        err_reg   <= err_next;
        out_reg   <= out_next;
    end

    // Prime table: written by load beats, read by the sieve.
    always_ff @(posedge clk)
    begin
        if (ptab_we)
            ptab_mem[TAW'(in_idx)] <= in_pval;
        ptab_rdata_reg <= ptab_mem[k_reg[TAW-1:0]];
    end

    // Cofactor store: one read and at most one write per cycle at the current index.
    always_ff @(posedge clk)
    begin
        if (cof_we)
            cof_mem[cof_addr] <= cof_wdata;
        cof_rdata_reg <= cof_mem[cof_addr];
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_vld_reg;

    // A flagged segment carries a zero count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[14:0] == '0)
        else $error("range error with nonzero count");

    // The divider is never busy while the block waits for a beat.
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_st.busy)
        else $error("divider busy in idle");

    // Cofactor writes stay inside the segment.
    a_cof_range: assert property (@(posedge clk) disable iff (!rst_n)
        cof_we |-> i_reg < IW'(len_reg))
        else $error("cofactor write outside segment");

    // A result is loaded only when the output register is free or being emptied.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result overwritten before it was taken");

endmodule
